[design/quadratic_probe_hash_table_macros.svh]
// assertion macros used by the checker of the hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// checked only while out of reset
`define QPHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every edge, reset included
`define QPHT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[design/qpht_pkg.sv]
package qpht_pkg;

	localparam int COURSE_W   = 16;
	localparam int YEAR_W     = 12;
	localparam int PROF_W     = 64;
	localparam int HANDLE_W   = 16;
	localparam int SIZE_W     = 9;
	localparam int SLOT_OUT_W = 8;
	localparam int PROBE_W    = 9;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 40;
	localparam int DIV_CNT_W  = $clog2(COURSE_W);
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	typedef enum logic [0:0] {
		ACT_INSERT = 1'b0,
		ACT_SEARCH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FOUND     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_PROBE,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                occupied;
		logic [COURSE_W-1:0] course;
		logic [YEAR_W-1:0]   year;
		logic [PROF_W-1:0]   prof;
		logic [HANDLE_W-1:0] handle;
	} slot_rec_t;

endpackage

[design/quadratic_probe_hash_table.sv]
// Open-addressing hash table with cumulative quadratic probing, keyed by course number.
// After reset the block sweeps every slot of the slot memory clear and holds s_tready
// low; configuration writes are taken meanwhile. Each item is then accepted, its home
// slot is found by a bit-serial remainder unit that works one course-number bit per
// cycle, each probe reads the memory and then compares, and the result is handed to
// the output register once that register is free. A search that misses always walks
// as many probes as the live table size. Only one item is in work at a time; a
// finished result may wait in the output register while the next item runs.
module quadratic_probe_hash_table #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0]          cfg_wdata,   // table_size
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// course_number[15:0], year[27:16], prof_id[91:28], record_handle[107:92], zero pad
	input  logic [qpht_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,     // action
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// slot_index[7:0], probe_count[16:8], collision[17], found_handle[33:18], zero pad
	output logic [qpht_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser      // status
);
	import qpht_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW  = $clog2(TABLE_DEPTH + 1);
	localparam int NW1 = NW + 1;
	localparam int CW  = (NW > SIZE_W) ? NW : SIZE_W;
	localparam int SW  = (AW > SLOT_OUT_W) ? AW : SLOT_OUT_W;
	localparam int PW  = (NW > PROBE_W) ? NW : PROBE_W;

	// (a + b) mod m for a, b below m
	function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b,
			input logic [NW-1:0] m);
		logic [NW1-1:0] s;
		s = NW1'(a) + NW1'(b);
		if (s >= NW1'(m))
			s = s - NW1'(m);
		return s[AW-1:0];
	endfunction

	state_t                state_q, state_d;
	logic [SIZE_W-1:0]     table_size_q;
	logic [AW-1:0]         clr_addr_q;
	logic [NW-1:0]         n_live, n_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [NW-1:0]         rem_q;
	logic [NW1-1:0]        rem_sh, rem_nxt;
	logic [AW-1:0]         slot_q, sq_q, odd_q, probe_addr;
	logic [NW-1:0]         h_q;
	logic                  coll_q, found_q, hit, walk_end;
	logic                  m_tvalid_q;

	action_t               action_q;
	logic [COURSE_W-1:0]   course_q;
	logic [YEAR_W-1:0]     year_q;
	logic [PROF_W-1:0]     prof_q;
	logic [HANDLE_W-1:0]   handle_q;

	slot_rec_t             slot_mem_q [TABLE_DEPTH];
	slot_rec_t             rd_q, mem_wdata;
	logic                  mem_we, mem_re, out_load;
	logic [AW-1:0]         mem_waddr;

	status_t               res_status;
	logic [SW-1:0]         res_slot;
	logic [PW-1:0]         res_probes;
	logic                  res_coll;
	logic [HANDLE_W-1:0]   res_handle;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	status_t               m_tuser_q;

	// live size: zero acts as one, above the depth clamps to the depth
	always_comb begin
		if (table_size_q == '0)
			n_live = NW'(1);
		else if (CW'(table_size_q) > CW'(TABLE_DEPTH))
			n_live = NW'(TABLE_DEPTH);
		else
			n_live = NW'(table_size_q);
	end

	// bit-serial remainder for the home slot
	assign rem_sh  = {rem_q, course_q[div_cnt_q]};
	assign rem_nxt = (rem_sh >= NW1'(n_q)) ? rem_sh - NW1'(n_q) : rem_sh;

	assign probe_addr = mod_add(slot_q, sq_q, n_q);

	assign hit = (action_q == ACT_SEARCH) ?
		(rd_q.occupied && rd_q.course == course_q && rd_q.year == year_q &&
			rd_q.prof == prof_q) :
		!rd_q.occupied;
	assign walk_end = (h_q == n_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_addr_q == AW'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_HOME;
			ST_HOME:  if (div_cnt_q == '0) state_d = ST_PROBE;
			ST_PROBE: state_d = ST_CHECK;
			ST_CHECK: begin
				if (hit || walk_end)
					state_d = ST_DONE;
				else
					state_d = ST_PROBE;
			end
			ST_DONE:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{occupied: 1'b1, course: course_q, year: year_q, prof: prof_q,
			handle: handle_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_IDLE:  s_tready = 1'b1;
			ST_HOME:  ;
			ST_PROBE: mem_re = 1'b1;
			ST_CHECK: mem_we = (action_q == ACT_INSERT) && !rd_q.occupied;
			ST_DONE:  out_load = !m_tvalid_q || m_tready;
			default:  ;
		endcase
	end

	// result fields
	always_comb begin
		if (action_q == ACT_SEARCH)
			res_status = found_q ? STAT_FOUND : STAT_NOT_FOUND;
		else
			res_status = found_q ? STAT_INSERTED : STAT_FULL;
		res_slot   = found_q ? SW'(slot_q) : '0;
		res_probes = (action_q == ACT_SEARCH) ? PW'(h_q - NW'(1)) : PW'(h_q);
		res_coll   = (action_q == ACT_INSERT) && coll_q;
		res_handle = ((action_q == ACT_SEARCH) && found_q) ? rd_q.handle : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			table_size_q <= SIZE_RESET;
			clr_addr_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				table_size_q <= cfg_wdata;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					action_q  <= action_t'(s_tuser);
					course_q  <= s_tdata[15:0];
					year_q    <= s_tdata[27:16];
					prof_q    <= s_tdata[91:28];
					handle_q  <= s_tdata[107:92];
					n_q       <= n_live;
					rem_q     <= '0;
					div_cnt_q <= DIV_CNT_W'(COURSE_W - 1);
					coll_q    <= 1'b0;
				end
			end
			ST_HOME: begin
				rem_q     <= rem_nxt[NW-1:0];
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				if (div_cnt_q == '0) begin
					slot_q <= rem_nxt[AW-1:0];
					sq_q   <= '0;
					odd_q  <= mod_add('0, AW'(1), n_q);
					h_q    <= '0;
				end
			end
			ST_PROBE: begin
				// h*h kept incrementally: square += odd, odd += 2
				slot_q <= probe_addr;
				sq_q   <= mod_add(sq_q, odd_q, n_q);
				odd_q  <= mod_add(mod_add(odd_q, AW'(1), n_q), AW'(1), n_q);
				h_q    <= h_q + NW'(1);
			end
			ST_CHECK: begin
				found_q <= hit;
				if (h_q == NW'(1))
					coll_q <= rd_q.occupied;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {6'd0, res_handle, res_coll, res_probes[PROBE_W-1:0],
				res_slot[SLOT_OUT_W-1:0]};
		end
	end

	// slot memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= slot_mem_q[probe_addr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[design/qpht_checker.sv]
`include "quadratic_probe_hash_table_macros.svh"

module qpht_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [qpht_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic [1:0]                          m_tuser
);
	import qpht_pkg::*;

	logic                  out_stall;
	logic [OUT_DATA_W+1:0] out_word;
	logic                  search_res;
	logic                  empty_res;
	logic                  no_slot_handle;

	assign out_stall      = m_tvalid && !m_tready;
	assign out_word       = {m_tuser, m_tdata};
	assign search_res     = (m_tuser == STAT_FOUND) || (m_tuser == STAT_NOT_FOUND);
	assign empty_res      = (m_tuser == STAT_NOT_FOUND) || (m_tuser == STAT_FULL);
	assign no_slot_handle = (m_tdata[7:0] == 8'd0) && (m_tdata[33:18] == 16'd0);

	// a stalled result holds
	`QPHT_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_word), "stalled result changed")

	// the block works on one item at a time
	`QPHT_ASSERT(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "input taken twice in a row")

	// only inserts can report a collision
	`QPHT_ASSERT(a_coll_insert_only, m_tvalid && search_res |-> !m_tdata[17], "collision on a search")

	// misses and full inserts carry no slot and no handle
	`QPHT_ASSERT(a_miss_zero, m_tvalid && empty_res |-> no_slot_handle, "slot or handle set on a miss")

	// clearing pass: nothing taken or shown once reset has been seen
	`QPHT_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !m_tvalid && !s_tready, "handshake during reset")

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);
